/* src/dfbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dfbp_pkg
// Shared types and constants of the five-bit dictionary packer.
// ----------------------------------------------------------------------------
package dfbp_pkg;

    localparam int CODE_W      = 5;
    localparam int DICT_SIZE   = 31;
    localparam int SLOTS       = 8;
    localparam int SLOT_W      = 3;
    localparam int GROUP_W     = 40;
    localparam int GROUP_BYTES = 5;
    localparam int CNT_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int DICT_WORDS  = 4;

    localparam logic [CODE_W-1:0] END_MARKER = 5'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DICT_LEN   = 3'd0,
        CFG_CHARS_LO   = 3'd1,
        CFG_CHARS_MID  = 3'd2,
        CFG_CHARS_HIGH = 3'd3,
        CFG_CHARS_TOP  = 3'd4
    } t_cfg_index;

    typedef logic [DICT_WORDS-1:0][CFG_DATA_W-1:0] t_dict_words;

    // one flush or full group, as handed from the packer to the serializer
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [CNT_W-1:0]   count;
        logic               stream_end;
    } t_burst;

    // bytes needed to cover slots 0..slot, i.e. ceil(5*(slot+1)/8)
    function automatic logic [CNT_W-1:0] flush_count(input logic [SLOT_W-1:0] slot);
        logic [CNT_W-1:0] cnt;
        case (slot)
            3'd0:    cnt = 3'd1;
            3'd1:    cnt = 3'd2;
            3'd2:    cnt = 3'd2;
            3'd3:    cnt = 3'd3;
            3'd4:    cnt = 3'd4;
            3'd5:    cnt = 3'd4;
            3'd6:    cnt = 3'd5;
            default: cnt = 3'd5;
        endcase
        return cnt;
    endfunction

endpackage
`default_nettype wire

/* src/dfbp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dfbp_front
// Dictionary lookup and code packing. Stage A registers the match vector,
// stage B encodes it, fills the 40-bit group and queues finished bursts.
// ----------------------------------------------------------------------------
module dfbp_front
    import dfbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CODE_W-1:0] i_dict_len,
    input  wire t_dict_words       i_dict_words,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_stream_last,
    output logic                   o_push,
    output t_burst                 o_burst,
    input  wire logic              i_full
);

    logic [DICT_SIZE-1:0] w_match;
    logic                 r_a_valid;
    logic [DICT_SIZE-1:0] r_a_match;
    logic                 r_a_last;
    logic [SLOT_W-1:0]    r_slot;
    logic [GROUP_W-1:0]   r_group;
    logic [GROUP_W-1:0]   n_group;
    logic [CODE_W-1:0]    w_code;
    logic                 w_need_push;
    logic                 w_b_adv;

    for (genvar k = 0; k < DICT_SIZE; k++) begin : g_cmp
        assign w_match[k] = (i_dict_words[k >> 3][(k & 7) * BYTE_W +: BYTE_W] == i_data_byte)
                          && (CODE_W'(k) < i_dict_len);
    end

    // lowest matching position wins; end marker overrides on the final item
    always_comb begin
        w_code = i_dict_len;
        for (int k = DICT_SIZE - 1; k >= 0; k--) begin
            if (r_a_match[k]) begin
                w_code = CODE_W'(k);
            end
        end
        if (r_a_last) begin
            w_code = END_MARKER;
        end
    end

    always_comb begin
        n_group = r_group;
        for (int s = 0; s < SLOTS; s++) begin
            if (r_slot == SLOT_W'(s)) begin
                n_group[GROUP_W - 1 - CODE_W * s -: CODE_W] = w_code;
            end
        end
    end

    assign w_need_push = r_a_last || (r_slot == SLOT_W'(SLOTS - 1));
    assign w_b_adv     = r_a_valid && (!w_need_push || !i_full);
    assign o_ready     = !r_a_valid || w_b_adv;
    assign o_push      = w_b_adv && w_need_push;

    assign o_burst.group      = n_group;
    assign o_burst.count      = r_a_last ? flush_count(r_slot) : CNT_W'(GROUP_BYTES);
    assign o_burst.stream_end = r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_slot    <= '0;
            r_group   <= '0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_adv) begin
                if (w_need_push) begin
                    r_slot  <= '0;
                    r_group <= '0;
                end else begin
                    r_slot  <= r_slot + SLOT_W'(1);
                    r_group <= n_group;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_match <= w_match;
            r_a_last  <= i_stream_last;
        end
    end

endmodule
`default_nettype wire

/* src/dfbp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dfbp_queue
// Small burst queue between the packer and the byte serializer.
// ----------------------------------------------------------------------------
module dfbp_queue
    import dfbp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_burst i_push_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_burst      o_pop_data,
    output logic        o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_burst          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

/* src/dfbp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dfbp_back
// Byte serializer: takes bursts from the queue and sends them MSB byte first
// through a registered output stage.
// ----------------------------------------------------------------------------
module dfbp_back
    import dfbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    output logic                   o_pop,
    input  wire t_burst            i_burst,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [BYTE_W-1:0]      o_data,
    output logic                   o_last,
    output logic                   o_end
);

    logic [GROUP_W-1:0] r_cur;
    logic [CNT_W-1:0]   r_left;
    logic               r_end;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_data;
    logic               r_out_last;
    logic               r_out_end;
    logic               w_out_load;
    logic               w_take;
    logic               w_last_byte;

    assign w_out_load  = !r_out_valid || i_ready;
    assign w_take      = w_out_load && (r_left != '0);
    assign w_last_byte = (r_left == CNT_W'(1));
    // refill as the last byte of the current burst leaves, so bursts run gapless
    assign o_pop       = !i_empty && ((r_left == '0) || (w_take && w_last_byte));

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;
    assign o_end   = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_left <= i_burst.count;
            end else if (w_take) begin
                r_left <= r_left - CNT_W'(1);
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_burst.group;
            r_end <= i_burst.stream_end;
        end else if (w_take) begin
            r_cur <= {r_cur[GROUP_W-BYTE_W-1:0], BYTE_W'(0)};
        end
        if (w_take) begin
            r_out_data <= r_cur[GROUP_W-1 -: BYTE_W];
            r_out_last <= w_last_byte;
            r_out_end  <= r_end;
        end
    end

endmodule
`default_nettype wire

/* src/dictionary_five_bit_packer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dictionary_five_bit_packer_core
// Maps bytes to 5-bit dictionary codes and packs them into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one byte per transaction; tlast marks the final byte of a
//   stream, whose byte is dropped and replaced by the end marker code 31.
//   m_axis carries packed bytes; tlast closes the bytes caused by one input,
//   tuser is set on every byte of an end-of-stream flush. The cfg channel
//   (i_cfg_valid/o_cfg_ready) is always ready and writes dict_len (index 0) and
//   the four dictionary words (indexes 1..4); other indexes are ignored. It
//   must only be written while the block is idle; nothing enforces it.
// Timing:
//   One input transaction per cycle. The first byte of a burst passes stage
//   A, the queue and the serializer's burst and output registers; the rest
//   follow one per cycle. Each group of eight codes yields 5 bytes, a flush
//   1 to 5 bytes. A burst queue of QUEUE_DEPTH entries sits between the
//   packer and the serializer; the input stalls only when it is full.
// Reset:
//   Synchronous, active low; clears the dictionary, the partial group and
//   all queued bursts. When m_axis_tready is low the output byte holds and
//   backpressure reaches s_axis_tready once the queue fills.
// ----------------------------------------------------------------------------
module dictionary_five_bit_packer_core
    import dfbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  wire logic                  s_axis_tlast,   // stream_last
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [BYTE_W-1:0]          m_axis_tdata,   // [7:0] packed_byte
    output logic                       m_axis_tlast,   // burst_last
    output logic                       m_axis_tuser,   // [0] stream_end
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CODE_W-1:0] r_dict_len;
    t_dict_words       r_dict_words;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    t_burst q_wr_data;
    t_burst q_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict_len   <= '0;
            r_dict_words <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DICT_LEN:   r_dict_len      <= i_cfg_data[CODE_W-1:0];
                CFG_CHARS_LO:   r_dict_words[0] <= i_cfg_data;
                CFG_CHARS_MID:  r_dict_words[1] <= i_cfg_data;
                CFG_CHARS_HIGH: r_dict_words[2] <= i_cfg_data;
                CFG_CHARS_TOP:  r_dict_words[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dfbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dict_len    (r_dict_len),
        .i_dict_words  (r_dict_words),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data_byte   (s_axis_tdata),
        .i_stream_last (s_axis_tlast),
        .o_push        (q_push),
        .o_burst       (q_wr_data),
        .i_full        (q_full)
    );

    dfbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_wr_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_rd_data),
        .o_empty     (q_empty)
    );

    dfbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_burst (q_rd_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_end   (m_axis_tuser)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("burst pushed into full queue");

    a_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("burst popped from empty queue");

    a_burst_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_wr_data.count != '0 && q_wr_data.count <= CNT_W'(GROUP_BYTES)))
        else $error("burst byte count out of range");

    a_full_group_not_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && q_wr_data.count != CNT_W'(GROUP_BYTES)) |-> q_wr_data.stream_end)
        else $error("short burst without end of stream");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dictionary_five_bit_packer_core. A queue-fed stream
// driver and a clocked monitor run against a cycle-free model of the code
// lookup and the 40-bit group packing; every packed byte is matched in order.
// ----------------------------------------------------------------------------
module tb;
    import dfbp_pkg::*;

    localparam int IDLE_MAX      = 14;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int RANDOM_ITEMS  = 95;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_src_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              burst_last;
        logic              stream_end;
    } t_packed_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // packer model: configuration and partial group
    logic [CODE_W-1:0]  pred_len = '0;
    t_dict_words        pred_words = '0;
    logic [GROUP_W-1:0] pred_group = '0;
    logic [SLOT_W-1:0]  pred_slot = '0;
    t_packed_result     packed_expect_q[$];

    // dictionary as last written, used to aim the stimulus at real matches
    logic [CODE_W-1:0]  cur_len = '0;
    t_dict_words        cur_words = '0;

    t_src_item          byte_feed_q[$];
    int                 items_queued = 0;
    int                 mismatch_count = 0;
    int                 in_count = 0;
    int                 in_taken = 0;
    int                 in_gap = 0;
    int                 out_count = 0;
    int                 out_taken = 0;
    int                 out_gap = 0;
    int                 hold_req = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 stall_cycles = 0;
    logic               in_idle_on = 1'b1;
    logic               out_idle_on = 1'b1;

    dictionary_five_bit_packer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // lowest matching position wins; unmatched bytes take the length code
    function automatic logic [CODE_W-1:0] dict_code(input logic [BYTE_W-1:0] b);
        logic [CODE_W-1:0] code;
        int k;
        code = pred_len;
        for (k = DICT_SIZE - 1; k >= 0; k--) begin
            if (k < pred_len && pred_words[k / 8][(k % 8) * 8 +: 8] == b)
                code = CODE_W'(k);
        end
        return code;
    endfunction

    task automatic pack_item(input logic [BYTE_W-1:0] b, input logic fin);
        logic [CODE_W-1:0] code;
        t_packed_result r;
        int slot;
        int count;
        int i;
        slot = int'(pred_slot);
        code = fin ? END_MARKER : dict_code(b);
        pred_group[GROUP_W - 1 - CODE_W * slot -: CODE_W] = code;
        if (fin)
            count = (CODE_W * (slot + 1) + 7) / 8;
        else if (slot == SLOTS - 1)
            count = GROUP_BYTES;
        else
            count = 0;
        for (i = 0; i < count; i++) begin
            r.data       = pred_group[GROUP_W - 1 - BYTE_W * i -: BYTE_W];
            r.burst_last = (i == count - 1);
            r.stream_end = fin;
            packed_expect_q.push_back(r);
        end
        if (count != 0) begin
            pred_group = '0;
            pred_slot  = '0;
        end else begin
            pred_slot = pred_slot + SLOT_W'(1);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("mismatch on output transaction %0d: %s got %02h expected %02h",
                 out_count, what, got, want);
        mismatch_count++;
    endtask

    // monitor: config and input transactions feed the model, results are checked
    always @(posedge i_clk) begin
        t_packed_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DICT_LEN:   pred_len = i_cfg_data[CODE_W-1:0];
                    CFG_CHARS_LO:   pred_words[0] = i_cfg_data;
                    CFG_CHARS_MID:  pred_words[1] = i_cfg_data;
                    CFG_CHARS_HIGH: pred_words[2] = i_cfg_data;
                    CFG_CHARS_TOP:  pred_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pack_item(s_axis_tdata, s_axis_tlast);
                in_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (packed_expect_q.size() == 0) begin
                    flag_mismatch("unexpected byte", m_axis_tdata, 8'h00);
                end else begin
                    want = packed_expect_q.pop_front();
                    if (m_axis_tdata !== want.data)
                        flag_mismatch("packed_byte", m_axis_tdata, want.data);
                    if (m_axis_tlast !== want.burst_last)
                        flag_mismatch("burst_last", 8'(m_axis_tlast), 8'(want.burst_last));
                    if (m_axis_tuser !== want.stream_end)
                        flag_mismatch("stream_end", 8'(m_axis_tuser), 8'(want.stream_end));
                end
                out_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_MAX) begin
                $display("** dictionary_five_bit_packer_core: FAILED **");
                $finish;
            end
        end
    end

    // input driver: one item offered at a time, random gap after each transaction while in_idle_on is set
    always @(negedge i_clk) begin
        logic offer;
        t_src_item item;
        if (i_rst_n) begin
            offer = s_axis_tvalid;
            if (offer && in_count != in_taken) begin
                in_taken++;
                offer  = 1'b0;
                in_gap = in_idle_on ? int'($urandom_range(0, IDLE_MAX)) : 0;
            end
            if (!offer) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (byte_feed_q.size() != 0) begin
                    item = byte_feed_q.pop_front();
                    s_axis_tdata <= item.data;
                    s_axis_tlast <= item.last;
                    offer = 1'b1;
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // output side: random stall after each transaction while out_idle_on is set, plus a long hold-off on request
    always @(negedge i_clk) begin
        logic take;
        if (i_rst_n) begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (out_count != out_taken) begin
                out_taken = out_count;
                out_gap   = out_idle_on ? int'($urandom_range(0, IDLE_MAX)) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            m_axis_tready <= take;
        end
    end

    task automatic feed(input logic [BYTE_W-1:0] b, input logic fin);
        byte_feed_q.push_back('{b, fin});
        items_queued++;
    endtask

    // mostly dictionary hits, the rest arbitrary bytes
    function automatic logic [BYTE_W-1:0] pick_byte();
        int k;
        if (cur_len != 0 && $urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, int'(cur_len) - 1);
            return cur_words[k / 8][(k % 8) * 8 +: 8];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_stream(input int len, input logic close);
        int i;
        for (i = 0; i < len; i++)
            feed(pick_byte(), 1'b0);
        if (close)
            feed(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_word(input int mode);
        logic [CFG_DATA_W-1:0] w;
        int i;
        w = {$urandom, $urandom};
        if (mode == 0) begin
            w = '0;
        end else if (mode == 1) begin
            w = '1;
        end else if (mode == 2) begin
            // narrow alphabet: repeats and zero characters
            for (i = 0; i < 8; i++)
                w[i * 8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 :
                                8'(8'h40 + $urandom_range(0, 7));
        end
        return w;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_dictionary(input logic [CODE_W-1:0] len, input t_dict_words words);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(CFG_DICT_LEN, {junk[CFG_DATA_W-1:CODE_W], len});
        cfg_write(CFG_CHARS_LO, words[0]);
        cfg_write(CFG_CHARS_MID, words[1]);
        cfg_write(CFG_CHARS_HIGH, words[2]);
        cfg_write(CFG_CHARS_TOP, words[3]);
        // out-of-range index must leave everything alone
        cfg_write(CFG_IDX_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
        cur_len   = len;
        cur_words = words;
    endtask

    // all input consumed, all results seen, pipeline given time to go quiet
    task automatic wait_drained();
        while (byte_feed_q.size() != 0 || s_axis_tvalid || packed_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        int random_start;
        int n;
        int i;
        int mode;
        logic [CODE_W-1:0] len;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset dictionary is empty: every byte codes to zero, final byte to 31
        feed(8'hFF, 1'b0);
        feed(8'h00, 1'b1);
        wait_drained();

        // full dictionary with a repeated character and a zero character
        set_dictionary(5'd31, {64'hEE5E_5D5C_5B5A_5958, 64'h5756_5554_5352_5150,
                               64'h4F4E_4D4C_4B4A_4948, 64'h4746_45FF_0041_4241});
        @(posedge i_clk);
        feed(8'h41, 1'b0);
        feed(8'h42, 1'b0);
        feed(8'h00, 1'b0);
        feed(8'hFF, 1'b0);
        feed(8'h5E, 1'b0);
        feed(8'hEE, 1'b0);
        feed(8'h99, 1'b0);
        feed(8'h47, 1'b0);
        feed(8'h59, 1'b0);
        feed(8'hAA, 1'b1);
        wait_drained();

        // short dictionary: the zero character now lies beyond the length
        set_dictionary(5'd3, cur_words);
        @(posedge i_clk);
        feed(8'h00, 1'b0);
        feed(8'h41, 1'b0);
        feed(8'h42, 1'b0);
        feed(8'h44, 1'b1);
        feed(8'h41, 1'b1);
        feed(8'h41, 1'b0);
        feed(8'h42, 1'b0);
        feed(8'h00, 1'b0);
        feed(8'h13, 1'b0);
        feed(8'h37, 1'b0);
        feed(8'hFF, 1'b0);
        feed(8'h80, 1'b0);
        feed(8'h00, 1'b1);

        random_start = items_queued;
        phase = 0;
        while (items_queued - random_start < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(0, 3))
                0:       len = '0;
                1:       len = 5'd31;
                default: len = 5'($urandom_range(1, 30));
            endcase
            mode = $urandom_range(0, 3);
            set_dictionary(len, {rand_word(mode), rand_word(mode),
                                 rand_word(mode), rand_word(mode)});
            @(posedge i_clk);
            in_idle_on  = (phase % 4 == 0) || (phase % 4 == 2);
            out_idle_on = (phase % 4 <= 1);
            if (phase == 1) begin
                // sender runs flat out into a stalled output until the queue backs up
                hold_req++;
                queue_stream(40, 1'b1);
            end else begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    queue_stream($urandom_range(0, 12), $urandom_range(0, 4) != 0);
            end
            phase++;
        end
        wait_drained();

        if (mismatch_count == 0)
            $display("** dictionary_five_bit_packer_core: PASSED **");
        else
            $display("** dictionary_five_bit_packer_core: FAILED **");
        $finish;
    end

endmodule
